// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

// ----- hw/rtl/pisc_pkg.sv -----
// ----------------------------------------------------------------------------
// pisc_pkg
// types, codes and constants of the pi steering controller
// ----------------------------------------------------------------------------
`default_nettype none

package pisc_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MEAS_W      = 16;
    localparam int OPCODE_W    = 2;
    localparam int OUT_TDATA_W = 32;

    // reset values of the configuration registers
    localparam logic signed [15:0] RST_REFERENCE    = 16'sd3840;
    localparam logic [11:0]        RST_PROP_GAIN    = 12'd512;
    localparam logic [11:0]        RST_INTEG_GAIN   = 12'd1024;
    localparam logic [11:0]        RST_OVERALL_GAIN = 12'd256;
    localparam logic signed [7:0]  RST_INTEG_HIGH   = 8'sd20;
    localparam logic signed [7:0]  RST_INTEG_LOW    = 8'sd0;
    localparam logic [7:0]         RST_OUT_HIGH     = 8'd200;
    localparam logic [7:0]         RST_OUT_LOW      = 8'd0;

    // drive register reset and band edges
    localparam logic [7:0] RST_DRIVE     = 8'd160;
    localparam logic [7:0] BAND_FWD_LO   = 8'd124;
    localparam logic [7:0] BAND_FWD_HI   = 8'd155;
    localparam logic [7:0] BAND_REV_LO   = 8'd70;
    localparam logic [7:0] BAND_REV_HI   = 8'd100;
    localparam logic [7:0] DUTY_FULL     = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REFERENCE    = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_INTEG_GAIN   = 3'd2,
        CFG_OVERALL_GAIN = 3'd3,
        CFG_INTEG_HIGH   = 3'd4,
        CFG_INTEG_LOW    = 3'd5,
        CFG_OUT_HIGH     = 3'd6,
        CFG_OUT_LOW      = 3'd7
    } cfg_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MEASURE = 2'd0,
        OP_EVENT_A = 2'd1,
        OP_EVENT_B = 2'd2
    } opcode_t;

    typedef struct packed {
        logic signed [15:0] reference;
        logic [11:0]        prop_gain;
        logic [11:0]        integ_gain;
        logic [11:0]        overall_gain;
        logic signed [7:0]  integ_high;
        logic signed [7:0]  integ_low;
        logic [7:0]         out_high;
        logic [7:0]         out_low;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pisc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pisc_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module pisc_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pisc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pisc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pisc_pkg::cfg_t                         cfg
);

    pisc_pkg::cfg_t cfg_reg;
    pisc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (pisc_pkg::cfg_idx_t'(cfg_addr))
                pisc_pkg::CFG_REFERENCE:    cfg_next.reference    = cfg_wdata;
                pisc_pkg::CFG_PROP_GAIN:    cfg_next.prop_gain    = cfg_wdata[11:0];
                pisc_pkg::CFG_INTEG_GAIN:   cfg_next.integ_gain   = cfg_wdata[11:0];
                pisc_pkg::CFG_OVERALL_GAIN: cfg_next.overall_gain = cfg_wdata[11:0];
                pisc_pkg::CFG_INTEG_HIGH:   cfg_next.integ_high   = cfg_wdata[7:0];
                pisc_pkg::CFG_INTEG_LOW:    cfg_next.integ_low    = cfg_wdata[7:0];
                pisc_pkg::CFG_OUT_HIGH:     cfg_next.out_high     = cfg_wdata[7:0];
                pisc_pkg::CFG_OUT_LOW:      cfg_next.out_low      = cfg_wdata[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference    <= pisc_pkg::RST_REFERENCE;
            cfg_reg.prop_gain    <= pisc_pkg::RST_PROP_GAIN;
            cfg_reg.integ_gain   <= pisc_pkg::RST_INTEG_GAIN;
            cfg_reg.overall_gain <= pisc_pkg::RST_OVERALL_GAIN;
            cfg_reg.integ_high   <= pisc_pkg::RST_INTEG_HIGH;
            cfg_reg.integ_low    <= pisc_pkg::RST_INTEG_LOW;
            cfg_reg.out_high     <= pisc_pkg::RST_OUT_HIGH;
            cfg_reg.out_low      <= pisc_pkg::RST_OUT_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pi_steering_controller.sv -----
// ----------------------------------------------------------------------------
// pi_steering_controller
// pi position controller with integrator clamp and band-decoded bridge drive
// ----------------------------------------------------------------------------
//  channel   direction  payload                                     handshake
//  s_axis    in         tuser: opcode, tdata: measurement           tvalid/tready
//  m_axis    out        tdata: drive, fwd duty, rev duty, bridge    tvalid/tready
//  cfg       in         cfg_addr, cfg_wdata                         cfg_we
//
//  a measurement request steps through its states on one shared 13x31 signed
//  multiplier, used for the three gain products in turn; timer event requests
//  only decode the drive band and emit the result
//  s_tready is high only while the sequencer is idle
//  the result register holds a request until taken; the sequencer waits in its
//  last step while it is full
//  reset loads the register reset values; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module pi_steering_controller (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [pisc_pkg::MEAS_W-1:0]         s_tdata,   // measurement
    input  wire logic [pisc_pkg::OPCODE_W-1:0]       s_tuser,   // opcode
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // drive_value, forward_duty, reverse_duty, bridge_enable, zero fill
    output      logic [pisc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [pisc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [pisc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INTEG,
        ST_MUL_I,
        ST_SUM,
        ST_MUL_O,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    pisc_pkg::cfg_t cfg;

    pisc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // control state
    state_t                 state_reg,    state_next;
    logic signed [23:0]     integ_reg,    integ_next;
    logic [7:0]             drive_reg,    drive_next;
    logic [7:0]             fwd_reg,      fwd_next;
    logic [7:0]             rev_reg,      rev_next;
    logic                   bridge_reg,   bridge_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // payload
    pisc_pkg::opcode_t      op_reg,       op_next;
    logic signed [15:0]     meas_reg,     meas_next;
    logic signed [16:0]     err_reg,      err_next;
    logic signed [43:0]     prod_reg,     prod_next;
    logic signed [30:0]     acc_reg,      acc_next;
    logic [pisc_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared multiplier
    logic signed [12:0]     mul_a;
    logic signed [30:0]     mul_b;
    logic signed [43:0]     mul_p;

    // integrator path
    logic signed [18:0]     integ_sum;
    logic signed [18:0]     integ_biased;
    logic signed [10:0]     integ_whole;
    logic signed [10:0]     whole_hi;
    logic signed [10:0]     lim_high;
    logic signed [10:0]     lim_low;
    logic signed [18:0]     high_scaled;
    logic signed [18:0]     low_scaled;
    logic                   hi_hit;
    logic                   lo_hit;
    logic signed [18:0]     integ_clamped;

    // drive path
    logic signed [43:0]     drv_biased;
    logic signed [19:0]     drv_whole;
    logic signed [19:0]     drv_hi;
    logic signed [19:0]     drv_lim;
    logic signed [19:0]     out_high_ext;
    logic signed [19:0]     out_low_ext;

    logic                   s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        case (state_reg)
            ST_INTEG:
            begin
                mul_a = $signed({1'b0, cfg.prop_gain});
                mul_b = 31'(err_reg);
            end
            ST_MUL_I:
            begin
                mul_a = $signed({1'b0, cfg.integ_gain});
                mul_b = {{13{integ_reg[17]}}, integ_reg[17:0]};
            end
            ST_MUL_O:
            begin
                mul_a = $signed({1'b0, cfg.overall_gain});
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // integrator add and clamp, whole part truncated toward zero
    assign integ_sum    = {integ_reg[17], integ_reg[17:0]} + {{2{err_reg[16]}}, err_reg};
    assign integ_biased = integ_sum + (integ_sum[18] ? 19'sd255 : 19'sd0);
    assign integ_whole  = integ_biased[18:8];
    assign lim_high     = {{3{cfg.integ_high[7]}}, cfg.integ_high};
    assign lim_low      = {{3{cfg.integ_low[7]}}, cfg.integ_low};
    assign high_scaled  = {{3{cfg.integ_high[7]}}, cfg.integ_high, 8'd0};
    assign low_scaled   = {{3{cfg.integ_low[7]}}, cfg.integ_low, 8'd0};
    assign hi_hit       = (integ_whole > lim_high);
    assign whole_hi     = hi_hit ? lim_high : integ_whole;
    assign lo_hit       = (whole_hi < lim_low);

    always_comb
    begin
        if (lo_hit)
        begin
            integ_clamped = low_scaled;
        end
        else if (hi_hit)
        begin
            integ_clamped = high_scaled;
        end
        else
        begin
            integ_clamped = integ_sum;
        end
    end

    // drive truncation toward zero and saturation
    assign drv_biased   = prod_reg + (prod_reg[43] ? 44'sd16777215 : 44'sd0);
    assign drv_whole    = drv_biased[43:24];
    assign out_high_ext = {12'd0, cfg.out_high};
    assign out_low_ext  = {12'd0, cfg.out_low};
    assign drv_hi       = (drv_whole > out_high_ext) ? out_high_ext : drv_whole;
    assign drv_lim      = (drv_hi < out_low_ext) ? out_low_ext : drv_hi;

    always_comb
    begin
        state_next    = state_reg;
        integ_next    = integ_reg;
        drive_next    = drive_reg;
        fwd_next      = fwd_reg;
        rev_next      = rev_reg;
        bridge_next   = bridge_reg;
        m_tvalid_next = m_tvalid_reg;
        op_next       = op_reg;
        meas_next     = meas_reg;
        err_next      = err_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next    = pisc_pkg::opcode_t'(s_tuser);
                    meas_next  = s_tdata;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (op_reg)
                    pisc_pkg::OP_MEASURE:
                    begin
                        err_next   = {cfg.reference[15], cfg.reference}
                                   - {meas_reg[15], meas_reg};
                        state_next = ST_INTEG;
                    end
                    pisc_pkg::OP_EVENT_A:
                    begin
                        if (drive_reg >= pisc_pkg::BAND_FWD_LO &&
                            drive_reg <= pisc_pkg::BAND_FWD_HI)
                        begin
                            fwd_next    = pisc_pkg::DUTY_FULL;
                            rev_next    = '0;
                            bridge_next = 1'b1;
                        end
                        if (drive_reg > pisc_pkg::BAND_FWD_HI ||
                            drive_reg < pisc_pkg::BAND_REV_LO)
                        begin
                            fwd_next    = '0;
                            rev_next    = '0;
                            bridge_next = 1'b0;
                        end
                        state_next = ST_EMIT;
                    end
                    pisc_pkg::OP_EVENT_B:
                    begin
                        if (drive_reg >= pisc_pkg::BAND_REV_LO &&
                            drive_reg <= pisc_pkg::BAND_REV_HI)
                        begin
                            rev_next    = pisc_pkg::DUTY_FULL;
                            fwd_next    = '0;
                            bridge_next = 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_INTEG:
            begin
                integ_next = 24'(integ_clamped);
                prod_next  = mul_p;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                acc_next   = prod_reg[30:0];
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = acc_reg + prod_reg[30:0];
                state_next = ST_MUL_O;
            end
            ST_MUL_O:
            begin
                prod_next  = mul_p;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                drive_next = drv_lim[7:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {7'd0, bridge_reg, rev_reg, fwd_reg, drive_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            integ_reg    <= '0;
            drive_reg    <= pisc_pkg::RST_DRIVE;
            fwd_reg      <= '0;
            rev_reg      <= '0;
            bridge_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= pisc_pkg::OP_MEASURE;
            meas_reg     <= '0;
            err_reg      <= '0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            integ_reg    <= integ_next;
            drive_reg    <= drive_next;
            fwd_reg      <= fwd_next;
            rev_reg      <= rev_next;
            bridge_reg   <= bridge_next;
            m_tvalid_reg <= m_tvalid_next;
            op_reg       <= op_next;
            meas_reg     <= meas_next;
            err_reg      <= err_next;
            prod_reg     <= prod_next;
            acc_reg      <= acc_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pisc_checker.sv -----
// ----------------------------------------------------------------------------
// pisc_checker
// port-level checks of the pi steering controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pisc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [pisc_pkg::MEAS_W-1:0]         s_tdata,
    input wire logic [pisc_pkg::OPCODE_W-1:0]       s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [pisc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic                                cfg_we,
    input wire logic [pisc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input wire logic [pisc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [7:0] fwd;
    logic [7:0] rev;
    logic       bridge;
    logic       unused_ok;

    assign fwd       = m_tdata[15:8];
    assign rev       = m_tdata[23:16];
    assign bridge    = m_tdata[24];
    assign unused_ok = ^{s_tdata, s_tuser, cfg_we, cfg_addr, cfg_wdata};

    // one request at a time: not ready right after an accept
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a stalled result holds
    `ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // forward and reverse never driven together
    `ASSERT_SAME(a_no_shoot_through, m_tvalid, fwd == 8'd0 || rev == 8'd0)

    // bridge enabled only with exactly one full-duty direction
    `ASSERT_SAME(a_bridge_duty, m_tvalid && bridge,
                 (fwd == 8'd255 && rev == 8'd0) || (fwd == 8'd0 && rev == 8'd255))

    // zero fill above the bridge bit
    `ASSERT_SAME(a_zero_fill, m_tvalid && (unused_ok || !unused_ok), m_tdata[31:25] == 7'd0)

endmodule

bind pi_steering_controller pisc_checker u_pisc_checker (.*);

`default_nettype wire
